// File: hdl/acv_pkg.sv
`timescale 1ns / 1ps

package acv_pkg;

	localparam int CodeW = 12;
	localparam int FsW = 14;
	localparam int ProdW = CodeW + FsW;
	localparam int SegW = 8;
	localparam int NumBytes = 8;
	localparam int PosW = 3;

	localparam logic [FsW-1:0] FS_RESET = 14'd3000;
	localparam logic [FsW-1:0] FS_LIMIT = 14'd9999;
	localparam logic [CodeW-1:0] CODE_MAX = 12'd4095;
	localparam logic [PosW-1:0] POS_LAST = 3'd7;

	typedef logic [3:0] bcd_t;

	typedef struct packed {
		bcd_t th;
		bcd_t hu;
		bcd_t te;
		bcd_t un;
	} digits_t;

	localparam bcd_t BLANK = 4'd10;

	// active-low glyphs 0..9, then blank
	localparam logic [SegW-1:0] GLYPH [0:10] = '{
		8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90, 8'hFF
	};
	localparam logic [SegW-1:0] POINT_MASK = 8'h7F;

	function automatic logic [SegW-1:0] glyph(input bcd_t d);
		return (d <= BLANK) ? GLYPH[d] : GLYPH[BLANK];
	endfunction

	function automatic digits_t bcd_digits(input logic [FsW-1:0] v);
		digits_t d;
		logic [FsW-1:0] r1;
		logic [9:0] r2;
		logic [9:0] r3;
		logic [6:0] r4;
		logic [6:0] r5;
		d = '0;
		for (int k = 1; k <= 9; k++) begin
			if (v >= FsW'(k * 1000)) begin
				d.th = 4'(k);
			end
		end
		r1 = v - FsW'(d.th) * 14'd1000;
		r2 = r1[9:0];
		for (int k = 1; k <= 9; k++) begin
			if (r2 >= 10'(k * 100)) begin
				d.hu = 4'(k);
			end
		end
		r3 = r2 - 10'(d.hu) * 10'd100;
		r4 = r3[6:0];
		for (int k = 1; k <= 9; k++) begin
			if (r4 >= 7'(k * 10)) begin
				d.te = 4'(k);
			end
		end
		r5 = r4 - 7'(d.te) * 7'd10;
		d.un = r5[3:0];
		return d;
	endfunction

endpackage

// File: hdl/acv_arith.sv
`timescale 1ns / 1ps

module acv_arith (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [acv_pkg::CodeW-1:0]     adc_code,
	input  logic [acv_pkg::FsW-1:0]       full_scale,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [acv_pkg::FsW-1:0]       mv,
	output logic [acv_pkg::CodeW-1:0]     code
);

	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;
	logic [acv_pkg::CodeW-1:0] code_s1, code_s2, code_s3;
	logic [acv_pkg::ProdW-1:0] prod;
	logic [acv_pkg::ProdW-1:0] prod_s2;
	logic [acv_pkg::FsW-1:0] mv_s3;

	logic [acv_pkg::FsW-1:0] q0;
	logic [acv_pkg::FsW-1:0] r0;
	logic [1:0] r1;
	logic [12:0] r2;
	logic corr;
	logic [acv_pkg::FsW-1:0] mv_next;

	assign en3 = !v_s3 || out_ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	assign prod = acv_pkg::ProdW'(code_s1) * acv_pkg::ProdW'(full_scale);

	// divide by 2^12 - 1: fold the high part back into the low part twice
	assign q0 = prod_s2[acv_pkg::ProdW-1:12];
	assign r0 = acv_pkg::FsW'(prod_s2[11:0]) + q0;
	assign r1 = r0[13:12];
	assign r2 = 13'(r0[11:0]) + 13'(r1);
	assign corr = (r2 >= 13'(acv_pkg::CODE_MAX));
	assign mv_next = q0 + acv_pkg::FsW'(r1) + acv_pkg::FsW'(corr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			code_s1 <= adc_code;
		end
		if (en2) begin
			prod_s2 <= prod;
			code_s2 <= code_s1;
		end
		if (en3) begin
			mv_s3 <= mv_next;
			code_s3 <= code_s2;
		end
	end

	assign out_valid = v_s3;
	assign mv = mv_s3;
	assign code = code_s3;

	a_mv_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (mv_s3 <= acv_pkg::FS_LIMIT))
		else $error("scaled value out of range");

endmodule

// File: hdl/acv_fmt.sv
`timescale 1ns / 1ps

module acv_fmt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [acv_pkg::FsW-1:0]       mv,
	input  logic [acv_pkg::CodeW-1:0]     code,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [acv_pkg::SegW-1:0]      segment_byte,
	output logic [acv_pkg::PosW-1:0]      digit_position,
	output logic                          last_digit
);

	acv_pkg::digits_t dmv;
	acv_pkg::digits_t dcode;
	logic [acv_pkg::SegW-1:0] bytes_next [0:acv_pkg::NumBytes-1];
	logic [acv_pkg::SegW-1:0] bytes_s4 [0:acv_pkg::NumBytes-1];
	logic v_s4;
	logic [acv_pkg::PosW-1:0] pos_q;
	logic done;
	logic load;

	always_comb begin
		dmv = acv_pkg::bcd_digits(mv);
		dcode = acv_pkg::bcd_digits(acv_pkg::FsW'(code));
		bytes_next[0] = acv_pkg::glyph(dmv.th) & acv_pkg::POINT_MASK;
		bytes_next[1] = acv_pkg::glyph(dmv.hu);
		bytes_next[2] = acv_pkg::glyph(dmv.te);
		bytes_next[3] = acv_pkg::glyph(acv_pkg::BLANK);
		bytes_next[4] = acv_pkg::glyph(dcode.th);
		bytes_next[5] = acv_pkg::glyph(dcode.hu);
		bytes_next[6] = acv_pkg::glyph(dcode.te);
		bytes_next[7] = acv_pkg::glyph(dcode.un);
	end

	assign done = v_s4 && out_ready && (pos_q == acv_pkg::POS_LAST);
	assign load = !v_s4 || done;
	assign in_ready = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			pos_q <= '0;
		end else begin
			if (load) begin
				v_s4 <= in_valid;
			end
			if (v_s4 && out_ready) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			bytes_s4 <= bytes_next;
		end
	end

	assign out_valid = v_s4;
	assign segment_byte = bytes_s4[pos_q];
	assign digit_position = pos_q;
	assign last_digit = (pos_q == acv_pkg::POS_LAST);

	a_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q != '0) |-> v_s4)
		else $error("run position advanced without a held item");

	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (pos_q == '0))
		else $error("position did not wrap after last byte");

endmodule

// File: hdl/adc_code_to_seven_segment_voltmeter.sv
`timescale 1ns / 1ps

// An item's first byte passes registered stages s1, s2, s3 and serializer stage s4.
// Eight bytes per item, one byte per cycle from the serializer while out_ready is high.
// Input is taken while the serializer still sends the previous item's bytes.
// Reset (arst_n low): all stages empty, byte position 0, full scale 3000 mV.

module adc_code_to_seven_segment_voltmeter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [acv_pkg::CodeW-1:0]     adc_code,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [acv_pkg::SegW-1:0]      segment_byte,
	output logic [acv_pkg::PosW-1:0]      digit_position,
	output logic                          last_digit,
	input  logic                          cfg_we,
	input  logic [acv_pkg::FsW-1:0]       cfg_wdata
);

	logic [acv_pkg::FsW-1:0] fs_q;
	logic mid_valid;
	logic mid_ready;
	logic [acv_pkg::FsW-1:0] mid_mv;
	logic [acv_pkg::CodeW-1:0] mid_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q <= acv_pkg::FS_RESET;
		end else if (cfg_we) begin
			fs_q <= (cfg_wdata > acv_pkg::FS_LIMIT) ? acv_pkg::FS_LIMIT : cfg_wdata;
		end
	end

	acv_arith u_arith (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.adc_code   (adc_code),
		.full_scale (fs_q),
		.out_valid  (mid_valid),
		.out_ready  (mid_ready),
		.mv         (mid_mv),
		.code       (mid_code)
	);

	acv_fmt u_fmt (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (mid_valid),
		.in_ready       (mid_ready),
		.mv             (mid_mv),
		.code           (mid_code),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.segment_byte   (segment_byte),
		.digit_position (digit_position),
		.last_digit     (last_digit)
	);

	a_fs_range: assert property (@(posedge clk) disable iff (!arst_n)
		fs_q <= acv_pkg::FS_LIMIT)
		else $error("full scale out of range");

endmodule
